@@ rtl/ola_pkg.sv @@
// Shared types and codes for the ordered array list engine.
package ola_pkg;

  typedef enum logic [2:0] {
    OP_APPEND  = 3'd0,
    OP_INSERT  = 3'd1,
    OP_REPLACE = 3'd2,
    OP_REMOVE  = 3'd3,
    OP_SEARCH  = 3'd4,
    OP_READ    = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_NOT_FOUND = 2'd1,
    STAT_BAD_POS   = 2'd2,
    STAT_FULL      = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SHIFT_UP,
    S_PLACE,
    S_SCAN,
    S_SHIFT_DN,
    S_READ,
    S_FINISH
  } state_e;

  typedef enum logic [2:0] {
    RD_NONE,
    RD_LAST,
    RD_FIRST,
    RD_POS,
    RD_NEXT,
    RD_PREV
  } rd_sel_e;

  typedef enum logic [2:0] {
    WR_NONE,
    WR_TAIL,
    WR_UP,
    WR_POS,
    WR_HERE,
    WR_DOWN
  } wr_sel_e;

  typedef enum logic [3:0] {
    RES_NONE,
    RES_OK_TAIL,
    RES_OK_POS,
    RES_OK_PTR,
    RES_OK_READ,
    RES_OK_ZERO,
    RES_NOT_FOUND,
    RES_BAD_POS,
    RES_FULL
  } res_sel_e;

  typedef struct packed {
    logic     load;
    rd_sel_e  rd;
    wr_sel_e  wr;
    res_sel_e res;
    logic     cnt_inc;
    logic     cnt_dec;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    op_e  op;
    logic full;
    logic empty;
    logic pos_bad;
    logic match;
    logic at_pos;
    logic last;
    logic out_free;
  } stat_t;

endpackage

@@ rtl/ola_ram.sv @@
// Generic single write port, single read port RAM with registered read data.
module ola_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AddrW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/ola_datapath.sv @@
// Datapath of the list engine: item registers, count, entry memory and result registers.
module ola_datapath #(
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AddrW = $clog2(DEPTH),
  localparam int unsigned CntW = $clog2(DEPTH + 1)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [2:0]         req_type_i,
  input  logic signed [31:0] value_i,
  input  logic signed [31:0] new_value_i,
  input  logic [7:0]         position_i,
  input  ola_pkg::cmd_t      cmd_i,
  output ola_pkg::stat_t     stat_o,
  input  logic               out_stall_i,
  output logic               out_valid_o,
  output logic [1:0]         status_o,
  output logic [7:0]         found_position_o,
  output logic signed [31:0] read_value_o,
  output logic [CntW-1:0]    entry_count_o
);
  import ola_pkg::*;

  localparam int unsigned PosW = (CntW > 8) ? CntW : 8;

  op_e                op_q;
  logic signed [31:0] val_q;
  logic signed [31:0] nval_q;
  logic [7:0]         pos_q;
  logic [CntW-1:0]    count_q;
  logic [AddrW-1:0]   ptr_q;

  status_e            res_status_q;
  logic [7:0]         res_fpos_q;
  logic signed [31:0] res_rval_q;

  logic               out_valid_q;
  logic [1:0]         out_status_q;
  logic [7:0]         out_fpos_q;
  logic signed [31:0] out_rval_q;
  logic [CntW-1:0]    out_count_q;

  logic               rd_en;
  logic [AddrW-1:0]   rd_addr;
  logic               wr_en;
  logic [AddrW-1:0]   wr_addr;
  logic [31:0]        wr_data;
  logic [31:0]        rdata;
  logic [AddrW-1:0]   pos_addr;
  logic [AddrW-1:0]   tail_addr;
  logic [CntW-1:0]    ptr_next;

  assign pos_addr  = AddrW'(pos_q);
  assign tail_addr = AddrW'(count_q);
  assign ptr_next  = CntW'(ptr_q) + CntW'(1);

  always_comb begin
    rd_en   = 1'b1;
    rd_addr = ptr_q;
    unique case (cmd_i.rd)
      RD_NONE:  rd_en   = 1'b0;
      RD_LAST:  rd_addr = AddrW'(count_q - CntW'(1));
      RD_FIRST: rd_addr = '0;
      RD_POS:   rd_addr = pos_addr;
      RD_NEXT:  rd_addr = ptr_q + AddrW'(1);
      RD_PREV:  rd_addr = ptr_q - AddrW'(1);
      default:  rd_en   = 1'b0;
    endcase
  end

  always_comb begin
    wr_en   = 1'b1;
    wr_addr = ptr_q;
    wr_data = rdata;
    unique case (cmd_i.wr)
      WR_NONE: wr_en = 1'b0;
      WR_TAIL: begin
        wr_addr = tail_addr;
        wr_data = val_q;
      end
      WR_UP:   wr_addr = ptr_q + AddrW'(1);
      WR_POS: begin
        wr_addr = pos_addr;
        wr_data = val_q;
      end
      WR_HERE: wr_data = nval_q;
      WR_DOWN: wr_addr = ptr_q - AddrW'(1);
      default: wr_en = 1'b0;
    endcase
  end

  ola_ram #(
    .WIDTH(32),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (wr_en),
    .waddr_i(wr_addr),
    .wdata_i(wr_data),
    .re_i   (rd_en),
    .raddr_i(rd_addr),
    .rdata_o(rdata)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q   <= op_e'(req_type_i);
      val_q  <= value_i;
      nval_q <= new_value_i;
      pos_q  <= position_i;
    end
    if (rd_en) begin
      ptr_q <= rd_addr;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.cnt_inc) begin
      count_q <= count_q + CntW'(1);
    end else if (cmd_i.cnt_dec) begin
      count_q <= count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.res)
      RES_NONE: ;
      RES_OK_TAIL: begin
        res_status_q <= STAT_OK;
        res_fpos_q   <= 8'(count_q);
        res_rval_q   <= '0;
      end
      RES_OK_POS: begin
        res_status_q <= STAT_OK;
        res_fpos_q   <= pos_q;
        res_rval_q   <= '0;
      end
      RES_OK_PTR: begin
        res_status_q <= STAT_OK;
        res_fpos_q   <= 8'(ptr_q);
        res_rval_q   <= '0;
      end
      RES_OK_READ: begin
        res_status_q <= STAT_OK;
        res_fpos_q   <= pos_q;
        res_rval_q   <= rdata;
      end
      RES_OK_ZERO: begin
        res_status_q <= STAT_OK;
        res_fpos_q   <= '0;
        res_rval_q   <= '0;
      end
      RES_NOT_FOUND: begin
        res_status_q <= STAT_NOT_FOUND;
        res_fpos_q   <= '0;
        res_rval_q   <= '0;
      end
      RES_BAD_POS: begin
        res_status_q <= STAT_BAD_POS;
        res_fpos_q   <= '0;
        res_rval_q   <= '0;
      end
      RES_FULL: begin
        res_status_q <= STAT_FULL;
        res_fpos_q   <= '0;
        res_rval_q   <= '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_status_q <= res_status_q;
      out_fpos_q   <= res_fpos_q;
      out_rval_q   <= res_rval_q;
      out_count_q  <= count_q;
    end
  end

  assign stat_o.op       = op_q;
  assign stat_o.full     = (count_q == CntW'(DEPTH));
  assign stat_o.empty    = (count_q == '0);
  assign stat_o.pos_bad  = (PosW'(pos_q) >= PosW'(count_q));
  assign stat_o.match    = (rdata == val_q);
  assign stat_o.at_pos   = (ptr_q == pos_addr);
  assign stat_o.last     = (ptr_next == count_q);
  assign stat_o.out_free = !out_valid_q || !out_stall_i;

  assign out_valid_o      = out_valid_q;
  assign status_o         = out_status_q;
  assign found_position_o = out_fpos_q;
  assign read_value_o     = out_rval_q;
  assign entry_count_o    = out_count_q;

endmodule

@@ rtl/ola_ctrl.sv @@
// Control state machine that sequences each list operation through the datapath.
module ola_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  ola_pkg::stat_t stat_i,
  output ola_pkg::cmd_t  cmd_o
);
  import ola_pkg::*;

  state_e state_q;
  state_e state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    cmd_o.rd      = RD_NONE;
    cmd_o.wr      = WR_NONE;
    cmd_o.res     = RES_NONE;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DECODE;
        end
      end
      S_DECODE: begin
        state_d = S_FINISH;
        unique case (stat_i.op) inside
          OP_APPEND: begin
            if (stat_i.full) begin
              cmd_o.res = RES_FULL;
            end else begin
              cmd_o.wr      = WR_TAIL;
              cmd_o.res     = RES_OK_TAIL;
              cmd_o.cnt_inc = 1'b1;
            end
          end
          OP_INSERT: begin
            if (stat_i.pos_bad) begin
              cmd_o.res = RES_BAD_POS;
            end else if (stat_i.full) begin
              cmd_o.res = RES_FULL;
            end else begin
              cmd_o.rd = RD_LAST;
              state_d  = S_SHIFT_UP;
            end
          end
          OP_REPLACE, OP_REMOVE, OP_SEARCH: begin
            if (stat_i.empty) begin
              cmd_o.res = RES_NOT_FOUND;
            end else begin
              cmd_o.rd = RD_FIRST;
              state_d  = S_SCAN;
            end
          end
          OP_READ: begin
            if (stat_i.pos_bad) begin
              cmd_o.res = RES_BAD_POS;
            end else begin
              cmd_o.rd = RD_POS;
              state_d  = S_READ;
            end
          end
          default: cmd_o.res = RES_OK_ZERO;
        endcase
      end
      S_SHIFT_UP: begin
        cmd_o.wr = WR_UP;
        if (stat_i.at_pos) begin
          state_d = S_PLACE;
        end else begin
          cmd_o.rd = RD_PREV;
        end
      end
      S_PLACE: begin
        cmd_o.wr      = WR_POS;
        cmd_o.res     = RES_OK_POS;
        cmd_o.cnt_inc = 1'b1;
        state_d       = S_FINISH;
      end
      S_SCAN: begin
        if (stat_i.match) begin
          cmd_o.res = RES_OK_PTR;
          state_d   = S_FINISH;
          unique case (stat_i.op)
            OP_REPLACE: cmd_o.wr = WR_HERE;
            OP_REMOVE: begin
              if (stat_i.last) begin
                cmd_o.cnt_dec = 1'b1;
              end else begin
                cmd_o.rd = RD_NEXT;
                state_d  = S_SHIFT_DN;
              end
            end
            default: ;
          endcase
        end else if (stat_i.last) begin
          cmd_o.res = RES_NOT_FOUND;
          state_d   = S_FINISH;
        end else begin
          cmd_o.rd = RD_NEXT;
        end
      end
      S_SHIFT_DN: begin
        cmd_o.wr = WR_DOWN;
        if (stat_i.last) begin
          cmd_o.cnt_dec = 1'b1;
          state_d       = S_FINISH;
        end else begin
          cmd_o.rd = RD_NEXT;
        end
      end
      S_READ: begin
        cmd_o.res = RES_OK_READ;
        state_d   = S_FINISH;
      end
      S_FINISH: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign in_stall_o = (state_q != S_IDLE);

endmodule

@@ rtl/ordered_array_list_engine.sv @@
// Top level of the ordered array list engine.
// The engine keeps an ordered list of up to DEPTH signed 32-bit entries in a
// single memory with one write and one registered read port, and handles one
// word at a time. A search, replace or remove walks the list at one entry per
// cycle, and a remove then moves each later entry down at one entry per cycle.
// An insert moves count minus position entries up at one per cycle and then
// writes the new word. A finished result sits in an output register, so the
// next word is accepted while the previous result is still stalled.
module ordered_array_list_engine #(
  parameter int unsigned DEPTH = 256,
  localparam int unsigned CntW = $clog2(DEPTH + 1)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [2:0]         req_type_i,
  input  logic signed [31:0] value_i,
  input  logic signed [31:0] new_value_i,
  input  logic [7:0]         position_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         status_o,
  output logic [7:0]         found_position_o,
  output logic signed [31:0] read_value_o,
  output logic [CntW-1:0]    entry_count_o
);
  import ola_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  ola_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  ola_datapath #(
    .DEPTH(DEPTH)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .req_type_i      (req_type_i),
    .value_i         (value_i),
    .new_value_i     (new_value_i),
    .position_i      (position_i),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .out_stall_i     (out_stall_i),
    .out_valid_o     (out_valid_o),
    .status_o        (status_o),
    .found_position_o(found_position_o),
    .read_value_o    (read_value_o),
    .entry_count_o   (entry_count_o)
  );

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (entry_count_o <= CntW'(DEPTH)))
    else $error("entry count exceeds the list depth");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("engine accepted a word without going busy");

  a_fail_pos_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o != STAT_OK)) |-> (found_position_o == 8'd0))
    else $error("failed request reports a nonzero position");

  a_fail_value_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o != STAT_OK)) |-> (read_value_o == 32'sd0))
    else $error("failed request reports a nonzero value");

  a_write_read_apart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.load |-> ((cmd.wr == WR_NONE) && (cmd.rd == RD_NONE))))
    else $error("memory access issued while loading a new word");

endmodule

@@ sim/ordered_array_list_engine_test.sv @@
// Self-checking testbench for the ordered array list engine with its own list predictor.
module ordered_array_list_engine_test;
  timeunit 1ns;
  timeprecision 1ps;

  import ola_pkg::*;

  localparam int DEPTH        = 256;
  localparam int POOL_SIZE    = 12;
  localparam int HOLD_CYCLES  = 400;
  localparam int SETTLE       = DEPTH + 40;
  localparam int LIMIT        = 3_000_000;
  localparam int MIX_FILL     = 0;
  localparam int MIX_BALANCED = 1;
  localparam int MIX_DRAIN    = 2;

  localparam logic [2:0] OP_UNUSED_LO = 3'd6;
  localparam logic [2:0] OP_UNUSED_HI = 3'd7;

  typedef struct packed {
    logic [2:0]         op;
    logic signed [31:0] value;
    logic signed [31:0] new_value;
    logic [7:0]         position;
  } list_req_t;

  typedef struct packed {
    status_e            status;
    logic [7:0]         pos;
    logic signed [31:0] data;
    logic [8:0]         count;
  } list_res_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [2:0]         req_type_i = '0;
  logic signed [31:0] value_i = '0;
  logic signed [31:0] new_value_i = '0;
  logic [7:0]         position_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [1:0]         status_o;
  logic [7:0]         found_position_o;
  logic signed [31:0] read_value_o;
  logic [8:0]         entry_count_o;

  list_req_t          req_q[$];
  list_res_t          result_q[$];
  logic signed [31:0] list_mem [DEPTH];
  int                 list_len = 0;
  logic signed [31:0] value_pool [POOL_SIZE];
  int                 send_idle_pct = 0;
  int                 recv_stall_pct = 0;
  bit                 hold_req = 1'b0;
  int                 hold_left = 0;
  int                 err_cnt = 0;
  int                 cycle_cnt = 0;

  ordered_array_list_engine #(.DEPTH(DEPTH)) dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .req_type_i       (req_type_i),
    .value_i          (value_i),
    .new_value_i      (new_value_i),
    .position_i       (position_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .status_o         (status_o),
    .found_position_o (found_position_o),
    .read_value_o     (read_value_o),
    .entry_count_o    (entry_count_o)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  function automatic list_res_t apply_list_request(list_req_t r);
    list_res_t res;
    int        hit;
    int        i;
    res.status = STAT_OK;
    res.pos    = '0;
    res.data   = '0;
    case (r.op)
      OP_APPEND: begin
        if (list_len >= DEPTH) begin
          res.status = STAT_FULL;
        end else begin
          list_mem[list_len] = r.value;
          res.pos = 8'(list_len);
          list_len++;
        end
      end
      OP_INSERT: begin
        if (r.position >= list_len) begin
          res.status = STAT_BAD_POS;
        end else if (list_len >= DEPTH) begin
          res.status = STAT_FULL;
        end else begin
          for (i = list_len; i > r.position; i--) list_mem[i] = list_mem[i - 1];
          list_mem[r.position] = r.value;
          res.pos = r.position;
          list_len++;
        end
      end
      OP_REPLACE, OP_REMOVE, OP_SEARCH: begin
        hit = -1;
        for (i = 0; i < list_len; i++) begin
          if (list_mem[i] == r.value) begin
            hit = i;
            break;
          end
        end
        if (hit < 0) begin
          res.status = STAT_NOT_FOUND;
        end else begin
          res.pos = 8'(hit);
          if (r.op == OP_REPLACE) begin
            list_mem[hit] = r.new_value;
          end else if (r.op == OP_REMOVE) begin
            for (i = hit; i + 1 < list_len; i++) list_mem[i] = list_mem[i + 1];
            list_len--;
          end
        end
      end
      OP_READ: begin
        if (r.position >= list_len) begin
          res.status = STAT_BAD_POS;
        end else begin
          res.pos  = r.position;
          res.data = list_mem[r.position];
        end
      end
      default: ;
    endcase
    res.count = 9'(list_len);
    return res;
  endfunction

  function automatic logic signed [31:0] pick_value(int pool_pct);
    if ($urandom_range(99, 0) < pool_pct) return value_pool[$urandom_range(POOL_SIZE - 1, 0)];
    return $urandom;
  endfunction

  function automatic void refresh_pool();
    value_pool[0] = 32'sh8000_0000;
    value_pool[1] = 32'sh7fff_ffff;
    value_pool[2] = '0;
    value_pool[3] = -32'sd1;
    for (int k = 4; k < POOL_SIZE; k++) value_pool[k] = $urandom;
  endfunction

  function automatic list_req_t random_request(int mix);
    list_req_t r;
    int        roll;
    int        cum [6];
    op_e       op_order [6];
    op_order = '{OP_APPEND, OP_INSERT, OP_REPLACE, OP_REMOVE, OP_SEARCH, OP_READ};
    case (mix)
      MIX_FILL:  cum = '{60, 75, 80, 85, 90, 98};
      MIX_DRAIN: cum = '{8, 15, 25, 75, 85, 98};
      default:   cum = '{18, 36, 51, 69, 83, 98};
    endcase
    roll = $urandom_range(99, 0);
    r.op = $urandom_range(1, 0) ? OP_UNUSED_HI : OP_UNUSED_LO;
    for (int k = 0; k < 6; k++) begin
      if (roll < cum[k]) begin
        r.op = op_order[k];
        break;
      end
    end
    r.value     = pick_value(70);
    r.new_value = pick_value(50);
    r.position  = $urandom_range(1, 0) ? 8'($urandom_range(255, 0)) : 8'($urandom_range(15, 0));
    return r;
  endfunction

  function automatic void queue_request(logic [2:0] op, logic signed [31:0] v,
                                        logic signed [31:0] nv, logic [7:0] p);
    req_q.push_back('{op: op, value: v, new_value: nv, position: p});
  endfunction

  task automatic wait_drained();
    while (req_q.size() != 0) @(negedge clk_i);
    while (result_q.size() != 0) @(negedge clk_i);
  endtask

  task automatic run_segment(int mix, int n, int idle_pct, int stall_pct, bit hold);
    @(negedge clk_i);
    refresh_pool();
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    hold_req       = hold;
    for (int k = 0; k < n; k++) req_q.push_back(random_request(mix));
    wait_drained();
  endtask

  // Driver: a word stays on the bus until it is taken, then the next one may follow.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) result_q.push_back(apply_list_request(req_q.pop_front()));
      if (!in_valid_i || !in_stall_o) begin
        if (req_q.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
          in_valid_i  <= 1'b1;
          req_type_i  <= req_q[0].op;
          value_i     <= req_q[0].value;
          new_value_i <= req_q[0].new_value;
          position_i  <= req_q[0].position;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_req) begin
      hold_left <= HOLD_CYCLES;
      hold_req  <= 1'b0;
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    list_res_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (result_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("unexpected result word: status %0d pos %0d value %0d count %0d",
                     status_o, found_position_o, read_value_o, entry_count_o);
        end else begin
          want = result_q.pop_front();
          if (status_o !== want.status || found_position_o !== want.pos ||
              read_value_o !== want.data || entry_count_o !== want.count) begin
            err_cnt++;
            if (err_cnt <= 10)
              $display("result mismatch: expected %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                       want.status, want.pos, want.data, want.count, status_o,
                       found_position_o, read_value_o, entry_count_o);
          end
        end
      end
      out_stall_i <= (hold_left != 0) || ($urandom_range(99, 0) < recv_stall_pct);
    end
  end

  initial begin
    while (cycle_cnt < LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    queue_request(OP_READ, '0, '0, 8'd0);
    queue_request(OP_SEARCH, 32'sd5, '0, '0);
    queue_request(OP_REMOVE, 32'sd5, '0, '0);
    queue_request(OP_REPLACE, 32'sd5, 32'sd6, '0);
    queue_request(OP_INSERT, 32'sd7, '0, 8'd0);
    queue_request(OP_APPEND, 32'sh8000_0000, '0, '0);
    queue_request(OP_APPEND, 32'sh7fff_ffff, '0, '0);
    queue_request(OP_APPEND, '0, '0, '0);
    queue_request(OP_APPEND, -32'sd1, '0, '0);
    queue_request(OP_INSERT, 32'sd42, '0, 8'd0);
    queue_request(OP_INSERT, 32'sd43, '0, 8'd255);
    queue_request(OP_SEARCH, 32'sh8000_0000, '0, '0);
    queue_request(OP_SEARCH, 32'sd42, '0, '0);
    queue_request(OP_REPLACE, 32'sd42, 32'sh5a5a_5a5a, '0);
    queue_request(OP_READ, '0, '0, 8'd0);
    queue_request(OP_READ, '0, '0, 8'd4);
    queue_request(OP_READ, '0, '0, 8'd5);
    queue_request(OP_REMOVE, 32'sh5a5a_5a5a, '0, '0);
    queue_request(OP_REMOVE, -32'sd1, '0, '0);
    queue_request(OP_UNUSED_LO, $urandom, $urandom, 8'($urandom));
    queue_request(OP_UNUSED_HI, -32'sd1, -32'sd1, 8'd255);
    queue_request(OP_SEARCH, 32'sd12345, '0, '0);
    queue_request(OP_REPLACE, 32'sd12345, -32'sd1, '0);
    wait_drained();
    run_segment(MIX_FILL, 450, 0, 0, 1'b0);
    run_segment(MIX_BALANCED, 350, 57, 0, 1'b0);
    run_segment(MIX_DRAIN, 450, 0, 57, 1'b1);
    run_segment(MIX_BALANCED, 450, 29, 29, 1'b0);
    repeat (SETTLE) @(negedge clk_i);
    if (err_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
